[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/lpht_pkg.sv]
package lpht_pkg;

  localparam int DEF_TABLE_SIZE = 256;
  localparam int KEY_W          = 32;
  localparam int PAY_W          = 32;
  localparam int SLOT_IDX_W     = 8;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_INSERT = 2'd0;
  localparam cmd_code_t CMD_LOOKUP = 2'd1;
  localparam cmd_code_t CMD_DELETE = 2'd2;
  localparam cmd_code_t CMD_UPDATE = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_DUP  = 2'd2;
  localparam status_t ST_FULL = 2'd3;

  // slot marks, code three is never written and reads like a tombstone
  typedef logic [1:0] mark_t;
  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_LIVE  = 2'd1;
  localparam mark_t MARK_TOMB  = 2'd2;

  typedef struct packed {
    mark_t              mark;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic hash;
    logic launch;
    logic probe;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic need_hash;
    logic hash_last;
    logic early_full;
    logic probe_end;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/lpht_ram.sv]
module lpht_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/lpht_ctrl.sv]
module lpht_ctrl import lpht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LAUNCH,
    S_PROBE,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.need_hash ? S_HASH : S_LAUNCH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (stat.hash_last) begin
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        cmd.launch = 1'b1;
        state_nxt  = stat.early_full ? S_RESP : S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.probe_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[hw/rtl/lpht_datapath.sv]
module lpht_datapath import lpht_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  cmd_code_t               in_command,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [PAY_W-1:0]        in_payload,
  input  logic                    out_stall,
  output logic                    out_valid,
  output status_t                 out_status,
  output logic [SLOT_IDX_W-1:0]   out_slot_index,
  output logic [PAY_W-1:0]        out_found_payload
);

  localparam int SLOT_W  = $clog2(TABLE_SIZE);
  localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(TABLE_SIZE - 1);

  // held transaction
  cmd_code_t          cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [PAY_W-1:0]   pay_r;

  // probe walk
  logic [SLOT_W-1:0]  probe_addr_r;
  logic [SLOT_W-1:0]  seen_r;
  logic               have_free_r;
  logic [SLOT_W-1:0]  free_at_r;
  logic [CNT_W-1:0]   live_count_r;

  // finished result and output register
  status_t            res_status_r;
  logic [SLOT_W-1:0]  res_slot_r;
  logic [PAY_W-1:0]   res_found_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic [PAY_W-1:0]   out_found_r;

  logic [SLOT_W-1:0]  home_slot;
  logic [SLOT_W-1:0]  probe_next;
  entry_t             rd_q;
  entry_t             wr_entry;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;

  logic               is_empty;
  logic               is_free;
  logic               key_hit;
  logic               at_last;
  logic               cand_have;
  logic [SLOT_W-1:0]  cand_addr;
  logic               chain_end;
  status_t            p_status;
  logic [SLOT_W-1:0]  p_slot;
  logic [PAY_W-1:0]   p_found;
  logic               cnt_inc;
  logic               cnt_dec;
  logic [SLOT_W+SLOT_IDX_W-1:0] slot_ext;

  // home slot: mask for power-of-two sizes, reciprocal remainder otherwise
  if (IS_POW2) begin : g_mask
    assign home_slot      = key_r[SLOT_W-1:0];
    assign stat.need_hash = 1'b0;
    assign stat.hash_last = 1'b1;
  end else begin : g_rem
    localparam longint unsigned KEY_SPAN = 64'h1_0000_0000;
    // truncated reciprocal, the quotient comes out low by at most one
    localparam logic [KEY_W-1:0] RECIP    = KEY_W'(KEY_SPAN / TABLE_SIZE);
    localparam logic [KEY_W-1:0] MOD_K    = KEY_W'(TABLE_SIZE);
    localparam logic [SLOT_W:0]  MODULUS  = (SLOT_W + 1)'(TABLE_SIZE);
    // two to the 32 modulo the size, taken back out for negative keys
    localparam logic [SLOT_W:0]  WRAP_REM = (SLOT_W + 1)'(KEY_SPAN % TABLE_SIZE);
    localparam logic [1:0]       STEP_MUL = 2'd0;
    localparam logic [1:0]       STEP_SUB = 2'd1;
    localparam logic [1:0]       STEP_FIX = 2'd2;
    logic [1:0]         step_r;
    logic [KEY_W-1:0]   quot_r;
    logic [SLOT_W:0]    est_r;
    logic [SLOT_W-1:0]  rem_r;
    logic [2*KEY_W-1:0] prod;
    logic [KEY_W-1:0]   diff;
    logic [SLOT_W:0]    rem_pos;
    logic [SLOT_W:0]    rem_fix;

    assign prod = (2*KEY_W)'(key_r) * (2*KEY_W)'(RECIP);
    // true difference lies below twice the size, so the low bits are exact
    assign diff = key_r - quot_r * MOD_K;

    always_comb begin
      rem_pos = (est_r >= MODULUS) ? est_r - MODULUS : est_r;
      if (!key_r[KEY_W-1]) begin
        rem_fix = rem_pos;
      end else if (rem_pos >= WRAP_REM) begin
        rem_fix = rem_pos - WRAP_REM;
      end else begin
        rem_fix = rem_pos + MODULUS - WRAP_REM;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        step_r <= STEP_MUL;
      end else if (cmd.hash) begin
        step_r <= step_r + 2'd1;
        case (step_r)
          STEP_MUL: begin
            quot_r <= prod[2*KEY_W-1:KEY_W];
          end
          STEP_SUB: begin
            est_r <= diff[SLOT_W:0];
          end
          default: begin
            rem_r <= rem_fix[SLOT_W-1:0];
          end
        endcase
      end
    end

    assign home_slot      = rem_r;
    assign stat.need_hash = 1'b1;
    assign stat.hash_last = (step_r == STEP_FIX);
  end

  assign probe_next = (probe_addr_r == LAST_SLOT) ? '0 : probe_addr_r + SLOT_W'(1);

  assign is_empty  = (rd_q.mark == MARK_EMPTY);
  assign is_free   = (rd_q.mark != MARK_LIVE);
  assign key_hit   = (rd_q.mark == MARK_LIVE) && (rd_q.key == key_r);
  assign at_last   = (seen_r == LAST_SLOT);
  assign cand_have = have_free_r || is_free;
  assign cand_addr = have_free_r ? free_at_r : probe_addr_r;
  assign chain_end = is_empty || key_hit || at_last;

  always_comb begin
    p_status = ST_MISS;
    p_slot   = '0;
    p_found  = '0;
    wr_en    = 1'b0;
    wr_addr  = probe_addr_r;
    wr_entry = '{mark: MARK_EMPTY, key: '0, payload: '0};
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.probe && chain_end) begin
      if (cmd_r == CMD_INSERT) begin
        if (key_hit) begin
          p_status = ST_DUP;
        end else if (cand_have) begin
          p_status = ST_DONE;
          p_slot   = cand_addr;
          wr_en    = 1'b1;
          wr_addr  = cand_addr;
          wr_entry = '{mark: MARK_LIVE, key: key_r, payload: pay_r};
          cnt_inc  = 1'b1;
        end else begin
          p_status = ST_FULL;
        end
      end else if (key_hit) begin
        p_status = ST_DONE;
        p_slot   = probe_addr_r;
        case (cmd_r)
          CMD_LOOKUP: begin
            p_found = rd_q.payload;
          end
          CMD_DELETE: begin
            wr_en    = 1'b1;
            wr_entry = '{mark: MARK_TOMB, key: rd_q.key, payload: rd_q.payload};
            cnt_dec  = (live_count_r != '0);
          end
          CMD_UPDATE: begin
            wr_en    = 1'b1;
            wr_entry = '{mark: MARK_LIVE, key: rd_q.key, payload: pay_r};
          end
          default: begin
            p_found = '0;
          end
        endcase
      end
    end
  end

  assign rd_en   = cmd.launch || cmd.probe;
  assign rd_addr = cmd.launch ? home_slot : probe_next;

  lpht_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_addr_r <= '0;
      have_free_r  <= 1'b0;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        probe_addr_r <= probe_next;
      end else if (cmd.launch) begin
        probe_addr_r <= home_slot;
        have_free_r  <= 1'b0;
      end else if (cmd.probe) begin
        probe_addr_r <= probe_next;
        if (!have_free_r && is_free) begin
          have_free_r <= 1'b1;
        end
      end
      if (cnt_inc) begin
        live_count_r <= live_count_r + CNT_W'(1);
      end else if (cnt_dec) begin
        live_count_r <= live_count_r - CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_ext = {{SLOT_IDX_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      key_r <= in_key;
      pay_r <= in_payload;
    end
    if (cmd.launch) begin
      seen_r       <= '0;
      res_status_r <= ST_FULL;
      res_slot_r   <= '0;
      res_found_r  <= '0;
    end else if (cmd.probe) begin
      seen_r <= seen_r + SLOT_W'(1);
      if (!have_free_r && is_free) begin
        free_at_r <= probe_addr_r;
      end
      if (chain_end) begin
        res_status_r <= p_status;
        res_slot_r   <= p_slot;
        res_found_r  <= p_found;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= slot_ext[SLOT_IDX_W-1:0];
      out_found_r  <= res_found_r;
    end
  end

  assign stat.clear_last = (probe_addr_r == LAST_SLOT);
  assign stat.early_full = (cmd_r == CMD_INSERT) && (live_count_r >= FULL_COUNT);
  assign stat.probe_end  = chain_end;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_slot_r;
  assign out_found_payload = out_found_r;

endmodule

[hw/rtl/linear_probe_hash_table_top.sv]
// channel   direction  handshake           fields
// in_       input      in_valid/in_stall   in_command, in_key, in_payload
// out_      output     out_valid/out_stall out_status, out_slot_index, out_found_payload
//
// sequence: load, launch, probe n slots (1 up to TABLE_SIZE), one slot a cycle through
//   the single read port of the slot memory, respond; non-power-of-two sizes add a
//   reciprocal remainder before launch; an insert at the fill limit skips the probe walk
// reset: a clearing sweep marks every slot empty, with in_stall high throughout
// stalls: a finished result sits in the output register, so the next transaction is
//   taken while it waits; a second result holds in the datapath until the first leaves
`include "assert_macros.svh"

module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cmd_code_t               in_command,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [PAY_W-1:0]        in_payload,
  // response channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output status_t                 out_status,
  output logic [SLOT_IDX_W-1:0]   out_slot_index,
  output logic [PAY_W-1:0]        out_found_payload
);

  // command and status between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: sweep, hash, launch, probe, respond
  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // slot memory, probe walk, live count and output register
  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_found_payload (out_found_payload)
  );

  // one transaction in flight: an accepted request closes the input at once
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // anything but success carries a zero slot and zero payload
  `ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_DONE),
                (out_slot_index == 8'd0) && (out_found_payload == 32'd0))

  // the output register is only loaded when it is free
  `ASSERT_IMPLY(a_load_free, clk, rst_n, dp_cmd.load_out, dp_stat.out_free)

  // probe launch never overlaps hashing or probing
  `ASSERT_IMPLY(a_launch_alone, clk, rst_n, dp_cmd.launch, !dp_cmd.probe && !dp_cmd.hash)

endmodule

[verif/lpht_checker.sv]
module lpht_checker import lpht_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  cmd_code_t             in_command,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [PAY_W-1:0]      in_payload,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  status_t               out_status,
  input  logic [SLOT_IDX_W-1:0] out_slot_index,
  input  logic [PAY_W-1:0]      out_found_payload,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct {
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [PAY_W-1:0]      found;
  } table_answer_t;

  // shadow copy of the slot store
  mark_t            mark_q[TABLE_SIZE];
  logic [KEY_W-1:0] key_q[TABLE_SIZE];
  logic [PAY_W-1:0] pay_q[TABLE_SIZE];
  int unsigned      live_entries;

  table_answer_t answers_due[$];
  int            fail_tally = 0;
  int            pending_answers = 0;

  assign mismatches  = fail_tally;
  assign outstanding = pending_answers;

  task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                 input logic [PAY_W-1:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    fail_tally++;
  endtask

  // non-negative remainder of the signed key
  function automatic int home_slot(logic [KEY_W-1:0] k);
    longint sk;
    sk = longint'($signed(k));
    return int'(((sk % TABLE_SIZE) + TABLE_SIZE) % TABLE_SIZE);
  endfunction

  function automatic table_answer_t apply_table_op(cmd_code_t op, logic [KEY_W-1:0] k,
                                                   logic [PAY_W-1:0] p);
    table_answer_t ans;
    int            home, idx, steps, free_at, hit;
    bit            have_free, dup, found_it, done;
    ans.status = ST_MISS;
    ans.slot   = '0;
    ans.found  = '0;
    home       = home_slot(k);
    idx        = home;
    steps      = 0;
    done       = 1'b0;
    have_free  = 1'b0;
    dup        = 1'b0;
    found_it   = 1'b0;
    free_at    = 0;
    hit        = 0;
    if (op == CMD_INSERT) begin
      if (live_entries >= TABLE_SIZE - 1) begin
        ans.status = ST_FULL;
      end else begin
        // walk the whole chain for a duplicate, remember the first reusable slot
        while (!done && steps < TABLE_SIZE) begin
          if (mark_q[idx] == MARK_EMPTY) begin
            if (!have_free) begin
              have_free = 1'b1;
              free_at   = idx;
            end
            done = 1'b1;
          end else if (mark_q[idx] == MARK_LIVE) begin
            if (key_q[idx] == k) begin
              dup  = 1'b1;
              done = 1'b1;
            end
          end else if (!have_free) begin
            have_free = 1'b1;
            free_at   = idx;
          end
          idx = (idx + 1) % TABLE_SIZE;
          steps++;
        end
        if (dup) begin
          ans.status = ST_DUP;
        end else if (!have_free) begin
          ans.status = ST_FULL;
        end else begin
          mark_q[free_at] = MARK_LIVE;
          key_q[free_at]  = k;
          pay_q[free_at]  = p;
          live_entries++;
          ans.status = ST_DONE;
          ans.slot   = SLOT_IDX_W'(free_at);
        end
      end
    end else begin
      while (!done && steps < TABLE_SIZE) begin
        if (mark_q[idx] == MARK_EMPTY) begin
          done = 1'b1;
        end else if (mark_q[idx] == MARK_LIVE && key_q[idx] == k) begin
          found_it = 1'b1;
          hit      = idx;
          done     = 1'b1;
        end
        idx = (idx + 1) % TABLE_SIZE;
        steps++;
      end
      if (found_it) begin
        ans.status = ST_DONE;
        ans.slot   = SLOT_IDX_W'(hit);
        if (op == CMD_LOOKUP) begin
          ans.found = pay_q[hit];
        end else if (op == CMD_DELETE) begin
          mark_q[hit] = MARK_TOMB;
          if (live_entries > 0) live_entries--;
        end else begin
          pay_q[hit] = p;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    table_answer_t want;
    if (!rst_n) begin
      for (int s = 0; s < TABLE_SIZE; s++) mark_q[s] = MARK_EMPTY;
      live_entries = 0;
      answers_due.delete();
    end else begin
      // results first, a transaction accepted now cannot answer at this edge
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_found_payload, '0);
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", PAY_W'(out_status), PAY_W'(want.status));
          if (out_slot_index !== want.slot)
            report_mismatch("slot_index", PAY_W'(out_slot_index), PAY_W'(want.slot));
          if (out_found_payload !== want.found)
            report_mismatch("found_payload", out_found_payload, want.found);
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(apply_table_op(in_command, in_key, in_payload));
    end
    pending_answers <= answers_due.size();
  end

endmodule

[verif/tb.sv]
module tb;
  import lpht_pkg::*;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // request side, all known from time zero
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  cmd_code_t               in_command = CMD_LOOKUP;
  logic signed [KEY_W-1:0] in_key     = '0;
  logic [PAY_W-1:0]        in_payload = '0;

  // response side
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  status_t               out_status;
  logic [SLOT_IDX_W-1:0] out_slot_index;
  logic [PAY_W-1:0]      out_found_payload;

  int mismatches;
  int outstanding;

  // idling control: idle_on flips in stretches, quiet turns idling off for the tail
  bit idle_on    = 1'b1;
  bit quiet      = 1'b0;
  int stall_left = 0;
  int items_sent = 0;

  // keys handed to the table, used to build hits, deletes and updates
  logic [KEY_W-1:0] key_pool[$];

  linear_probe_hash_table_top #(.TABLE_SIZE(DEF_TABLE_SIZE)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_found_payload(out_found_payload)
  );

  lpht_checker #(.TABLE_SIZE(DEF_TABLE_SIZE)) answer_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_found_payload(out_found_payload),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // response stall in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one transaction, optionally preceded by an idle burst; returns at the accepting edge
  task automatic send_op(input cmd_code_t op, input logic [KEY_W-1:0] k,
                         input logic [PAY_W-1:0] p);
    if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= op;
    in_key     <= k;
    in_payload <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // re-pick idling on or off every 64 transactions so quiet stretches occur too
    if (items_sent % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
  endtask

  // hold the request side until every outstanding answer is back
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // keys clustered around the wrap point and small signed values give long chains
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      1: return {r[31:8], 8'(8'd253 + $urandom_range(0, 5))};
      2: return r[0] ? 32'($urandom_range(0, 700)) : -32'($urandom_range(1, 700));
      default: return r;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    if (key_pool.size() == 0) return fresh_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // delete a key that was handed to the table earlier and forget it
  task automatic delete_known();
    logic [KEY_W-1:0] k;
    int               which;
    if (key_pool.size() == 0) begin
      k = fresh_key();
    end else begin
      which = $urandom_range(0, key_pool.size() - 1);
      k     = key_pool[which];
      key_pool.delete(which);
    end
    send_op(CMD_DELETE, k, $urandom);
  endtask

  // mixed traffic, mostly against keys already handed out
  task automatic random_op();
    logic [KEY_W-1:0] k;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 6) == 0) begin
        k = pool_key();
      end else begin
        k = fresh_key();
        key_pool.push_back(k);
      end
      send_op(CMD_INSERT, k, $urandom);
    end else if (pick < 60) begin
      send_op(CMD_LOOKUP, ($urandom_range(0, 4) == 0) ? fresh_key() : pool_key(), $urandom);
    end else if (pick < 80) begin
      if ($urandom_range(0, 5) == 0) send_op(CMD_DELETE, fresh_key(), $urandom);
      else delete_known();
    end else begin
      send_op(CMD_UPDATE, ($urandom_range(0, 4) == 0) ? fresh_key() : pool_key(), $urandom);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, key extremes, collisions at slot zero and the wrap point
    send_op(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);  // miss on empty table
    send_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);  // duplicate key
    send_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // -1 lands in the last slot
    send_op(CMD_INSERT, 32'h8000_0000, 32'h0000_0001);  // most negative, home zero
    send_op(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0002);  // most positive, chain wraps
    send_op(CMD_INSERT, 32'h0000_0100, 32'h0000_0003);
    send_op(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(CMD_UPDATE, 32'h8000_0000, 32'hA5A5_A5A5);
    send_op(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_op(CMD_DELETE, 32'h0000_0000, 32'h0000_0000);  // tombstone at the head
    send_op(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // miss through tombstone
    send_op(CMD_INSERT, 32'h0000_0100, 32'h5A5A_5A5A);  // duplicate found past tombstone
    send_op(CMD_INSERT, 32'h0000_0200, 32'h0000_0004);  // reuses the tombstone
    send_op(CMD_DELETE, 32'h0000_0000, 32'h0000_0000);  // delete miss
    send_op(CMD_UPDATE, 32'h0000_3039, 32'h1234_5678);  // update miss
    send_op(CMD_DELETE, 32'h8000_0000, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'h0000_0100, 32'h0000_0000);
    send_op(CMD_INSERT, 32'h0000_00FF, 32'hDEAD_BEEF);  // wraps into the new tombstone
    send_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    key_pool = {32'h0000_0100, 32'h0000_0200, 32'h0000_00FF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};

    // moderate load, mixed traffic
    repeat (700) random_op();

    // let everything drain before pushing the table to its fill limit
    drain_all();

    // fill past the live limit so inserts start answering full
    repeat (270) begin
      k = fresh_key();
      key_pool.push_back(k);
      send_op(CMD_INSERT, k, $urandom);
    end

    // churn at full load: tombstones get reused, the last empty slot gets taken,
    // and then every miss walks the whole ring
    repeat (100) begin
      delete_known();
      k = fresh_key();
      key_pool.push_back(k);
      send_op(CMD_INSERT, k, $urandom);
      send_op(CMD_LOOKUP, ($urandom_range(0, 1) != 0) ? fresh_key() : pool_key(), $urandom);
    end

    // tear the table down into tombstones
    repeat (260) begin
      if ($urandom_range(0, 3) == 0) send_op(CMD_LOOKUP, pool_key(), $urandom);
      else delete_known();
    end

    repeat (200) random_op();

    // tail of the run with no idling on either side
    quiet = 1'b1;
    repeat (200) random_op();

    drain_all();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
